// ----- rtl/sta_lta_motion_trigger_macros.svh -----
// assertion macros shared by the motion trigger rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef STA_LTA_MOTION_TRIGGER_MACROS_SVH
`define STA_LTA_MOTION_TRIGGER_MACROS_SVH

// property holds at every clock edge outside reset
`define SLMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SLMT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define SLMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/slmt_pkg.sv -----
// shared constants, codes and command types of the motion trigger
// no dependencies
`default_nettype none

package slmt_pkg;

  // ring lengths
  localparam int SHORT_LEN = 7;
  localparam int LONG_LEN  = 70;

  // sample and magnitude widths
  localparam int AXIS_W     = 16;
  localparam int N_AXES     = 6;
  localparam int AXIS_IDX_W = $clog2(N_AXES);
  localparam int IN_W       = N_AXES * AXIS_W;
  localparam int MAG_W      = 16;
  localparam int RAD_W      = 32;
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int CNT_W      = $clog2(ROOT_STEPS + 1);

  // result word
  localparam int N_FLAGS  = 4;
  localparam int OUT_W    = 8;
  localparam int F_ALARM  = 0;
  localparam int F_ACC    = 1;
  localparam int F_GYR    = 2;
  localparam int F_ARMED  = 3;

  // configuration
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int ACC_MULT_W  = 14;
  localparam int GYRO_MULT_W = 16;
  localparam int PERIOD_W    = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_MULT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_MULT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LTA_PERIOD = 2'd2;
  localparam int ACC_MULT_RST   = 10050;
  localparam int GYRO_MULT_RST  = 30000;
  localparam int LTA_PERIOD_RST = 250;

  // ring bookkeeping
  localparam int SPOS_W  = $clog2(SHORT_LEN);
  localparam int SFILL_W = $clog2(SHORT_LEN + 1);
  localparam int LPOS_W  = $clog2(LONG_LEN);
  localparam int SSUM_W  = MAG_W + SFILL_W;
  localparam int LSUM_W  = MAG_W + $clog2(LONG_LEN + 1);
  localparam int LR_W    = 2 * MAG_W;

  // ratio test operands
  localparam int M7_W    = GYRO_MULT_W + SFILL_W;
  localparam int LHS_K   = LONG_LEN * 10000;
  localparam int LK_W    = $clog2(LHS_K + 1);
  localparam int A_MAX0  = (LSUM_W > SSUM_W) ? LSUM_W : SSUM_W;
  localparam int MUL_A_W = (A_MAX0 > MAG_W) ? A_MAX0 : MAG_W;
  localparam int B_MAX0  = (LK_W > M7_W) ? LK_W : M7_W;
  localparam int MUL_B_W = (B_MAX0 > MAG_W) ? B_MAX0 : MAG_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // shared multiplier operand select
  localparam logic [2:0] MUL_SQ    = 3'd0;
  localparam logic [2:0] MUL_ACC_L = 3'd1;
  localparam logic [2:0] MUL_ACC_R = 3'd2;
  localparam logic [2:0] MUL_GYR_L = 3'd3;
  localparam logic [2:0] MUL_GYR_R = 3'd4;

  typedef struct packed {
    logic                  load;
    logic [AXIS_IDX_W-1:0] sq_idx;
    logic [2:0]            mul_sel;
    logic                  add_en;
    logic                  add_gyr;
    logic                  root_step;
    logic                  short_upd;
    logic                  long_wr;
    logic                  lhs_ld;
    logic                  acc_cmp;
    logic                  gyr_cmp;
    logic                  finish;
  } slmt_cmd_t;

  typedef struct packed {
    logic out_free;
    logic warm;
  } slmt_sts_t;

endpackage

`default_nettype wire

// ----- rtl/slmt_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module slmt_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/slmt_ctrl.sv -----
// sequencer of the motion trigger: steps one sample through the datapath
// depends on slmt_pkg and the assertion macro header
`default_nettype none
`include "sta_lta_motion_trigger_macros.svh"

module slmt_ctrl
  import slmt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  output logic           s_ready_o,
  input  wire slmt_sts_t sts_i,
  output slmt_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQ    = 3'd1;
  localparam logic [2:0] S_ROOT  = 3'd2;
  localparam logic [2:0] S_SHORT = 3'd3;
  localparam logic [2:0] S_LWR   = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_SQ;
    case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_SQ;
        end
      end
      S_SQ: begin
        // square axis n while adding the square of axis n-1
        if (cnt_q < CNT_W'(N_AXES)) begin
          cmd_o.sq_idx = cnt_q[AXIS_IDX_W-1:0];
        end
        cmd_o.add_en  = (cnt_q != '0);
        cmd_o.add_gyr = (cnt_q > CNT_W'(N_AXES / 2));
        if (cnt_q == CNT_W'(N_AXES)) begin
          cnt_d   = '0;
          state_d = S_ROOT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_SHORT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_SHORT: begin
        cmd_o.short_upd = 1'b1;
        state_d         = S_LWR;
      end
      S_LWR: begin
        cmd_o.long_wr = 1'b1;
        cnt_d         = '0;
        // warm-up has no ratio test
        state_d       = sts_i.warm ? S_FIN : S_CMP;
      end
      S_CMP: begin
        cnt_d = cnt_q + CNT_W'(1);
        case (cnt_q)
          CNT_W'(0): cmd_o.mul_sel = MUL_ACC_L;
          CNT_W'(1): begin
            cmd_o.lhs_ld  = 1'b1;
            cmd_o.mul_sel = MUL_ACC_R;
          end
          CNT_W'(2): begin
            cmd_o.acc_cmp = 1'b1;
            cmd_o.mul_sel = MUL_GYR_L;
          end
          CNT_W'(3): begin
            cmd_o.lhs_ld  = 1'b1;
            cmd_o.mul_sel = MUL_GYR_R;
          end
          default: begin
            cmd_o.gyr_cmp = 1'b1;
            state_d       = S_FIN;
          end
        endcase
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `SLMT_ASSERT_NEXT(a_load_starts_squares, cmd_o.load, state_q == S_SQ, "accepted word did not start squaring")
  `SLMT_ASSERT_IMPL(a_finish_needs_room, cmd_o.finish, sts_i.out_free, "result written over an untaken word")
  `SLMT_ASSERT_IMPL(a_root_count, state_q == S_ROOT, cnt_q < CNT_W'(ROOT_STEPS), "root step count overran")

endmodule

`default_nettype wire

// ----- rtl/slmt_dp.sv -----
// datapath of the motion trigger: squares, roots, rings, sums, ratio test
// depends on slmt_pkg, slmt_ram and the assertion macro header
`default_nettype none
`include "sta_lta_motion_trigger_macros.svh"

module slmt_dp
  import slmt_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire slmt_cmd_t             cmd_i,
  output slmt_sts_t                  sts_o,
  input  wire logic [IN_W-1:0]       s_data_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  m_ready_i,
  output logic                       m_valid_o,
  output logic [OUT_W-1:0]           m_data_o
);

  // configuration, multipliers kept pre-scaled by the short length
  logic [M7_W-1:0]     acc_m7_q, gyr_m7_q;
  logic [PERIOD_W-1:0] lta_q;

  // sample, multiplier and root registers
  logic [AXIS_W-1:0]  axis_q [N_AXES];
  logic [AXIS_W-1:0]  sq_raw, sq_abs;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_q, lhs_q;
  logic [RAD_W-1:0]   acc_n_q, gyr_n_q, acc_r_q, gyr_r_q, bit_q;
  logic [RAD_W:0]     acc_try, gyr_try;
  logic [MAG_W-1:0]   am, gm;

  // ring state
  logic [MAG_W-1:0]    acc_sring_q [SHORT_LEN];
  logic [MAG_W-1:0]    gyr_sring_q [SHORT_LEN];
  logic [SSUM_W-1:0]   acc_ssum_q, gyr_ssum_q;
  logic [LSUM_W-1:0]   acc_lsum_q, gyr_lsum_q;
  logic [SPOS_W-1:0]   spos_q;
  logic [SFILL_W-1:0]  sfill_q;
  logic [LPOS_W-1:0]   lpos_q;
  logic                long_full_q, push_q, warm_q;
  logic [PERIOD_W-1:0] period_q, per_eff;
  logic                per_hit;
  logic [LR_W-1:0]     lr_rdata;
  logic [MAG_W-1:0]    old_a, old_g;
  logic                lr_we;

  // result
  logic             acc_over_q, gyr_over_q;
  logic             acc_ok, gyr_ok, ratio_ok;
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;
  logic [OUT_W-1:0] out_word;

  assign am = acc_r_q[MAG_W-1:0];
  assign gm = gyr_r_q[MAG_W-1:0];

  // absolute value of the selected axis, -32768 maps to 32768
  assign sq_raw = axis_q[cmd_i.sq_idx];
  assign sq_abs = sq_raw[AXIS_W-1] ? (~sq_raw + AXIS_W'(1)) : sq_raw;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_SQ: begin
        mul_a = MUL_A_W'(sq_abs);
        mul_b = MUL_B_W'(sq_abs);
      end
      MUL_ACC_L: begin
        mul_a = MUL_A_W'(acc_ssum_q);
        mul_b = MUL_B_W'(LHS_K);
      end
      MUL_ACC_R: begin
        mul_a = MUL_A_W'(acc_lsum_q);
        mul_b = MUL_B_W'(acc_m7_q);
      end
      MUL_GYR_L: begin
        mul_a = MUL_A_W'(gyr_ssum_q);
        mul_b = MUL_B_W'(LHS_K);
      end
      MUL_GYR_R: begin
        mul_a = MUL_A_W'(gyr_lsum_q);
        mul_b = MUL_B_W'(gyr_m7_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // one bit of each root per step
  assign acc_try = {1'b0, acc_r_q} + {1'b0, bit_q};
  assign gyr_try = {1'b0, gyr_r_q} + {1'b0, bit_q};

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.lhs_ld) begin
      lhs_q <= prod_q;
    end
    if (cmd_i.load) begin
      for (int i = 0; i < N_AXES; i++) begin
        axis_q[i] <= s_data_i[i*AXIS_W +: AXIS_W];
      end
      acc_n_q <= '0;
      gyr_n_q <= '0;
      acc_r_q <= '0;
      gyr_r_q <= '0;
      bit_q   <= RAD_W'(1) << (RAD_W - 2);
    end else if (cmd_i.add_en) begin
      if (cmd_i.add_gyr) begin
        gyr_n_q <= gyr_n_q + prod_q[RAD_W-1:0];
      end else begin
        acc_n_q <= acc_n_q + prod_q[RAD_W-1:0];
      end
    end else if (cmd_i.root_step) begin
      if ({1'b0, acc_n_q} >= acc_try) begin
        acc_n_q <= acc_n_q - acc_try[RAD_W-1:0];
        acc_r_q <= (acc_r_q >> 1) + bit_q;
      end else begin
        acc_r_q <= acc_r_q >> 1;
      end
      if ({1'b0, gyr_n_q} >= gyr_try) begin
        gyr_n_q <= gyr_n_q - gyr_try[RAD_W-1:0];
        gyr_r_q <= (gyr_r_q >> 1) + bit_q;
      end else begin
        gyr_r_q <= gyr_r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // long ring period, zero acts as one
  assign per_eff = (lta_q == '0) ? PERIOD_W'(1) : lta_q;
  assign per_hit = ({1'b0, period_q} + (PERIOD_W + 1)'(1)) >= {1'b0, per_eff};

  assign lr_we = cmd_i.long_wr && push_q;
  assign old_a = long_full_q ? lr_rdata[MAG_W-1:0] : '0;
  assign old_g = long_full_q ? lr_rdata[LR_W-1:MAG_W] : '0;

  slmt_ram #(
    .Width (LR_W),
    .Depth (LONG_LEN)
  ) u_long_ring (
    .clk_i   (clk_i),
    .we_i    (lr_we),
    .waddr_i (lpos_q),
    .wdata_i ({gm, am}),
    .re_i    (cmd_i.short_upd),
    .raddr_i (lpos_q),
    .rdata_o (lr_rdata)
  );

  // ratio test counts only with both rings full
  assign ratio_ok = !warm_q && (sfill_q == SFILL_W'(SHORT_LEN));
  assign acc_ok   = acc_over_q && ratio_ok;
  assign gyr_ok   = gyr_over_q && ratio_ok;

  // result word, padding bits zero
  always_comb begin
    out_word          = '0;
    out_word[F_ALARM] = acc_ok || gyr_ok;
    out_word[F_ACC]   = acc_ok;
    out_word[F_GYR]   = gyr_ok;
    out_word[F_ARMED] = long_full_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_m7_q    <= M7_W'(SHORT_LEN * ACC_MULT_RST);
      gyr_m7_q    <= M7_W'(SHORT_LEN * GYRO_MULT_RST);
      lta_q       <= PERIOD_W'(LTA_PERIOD_RST);
      for (int i = 0; i < SHORT_LEN; i++) begin
        acc_sring_q[i] <= '0;
        gyr_sring_q[i] <= '0;
      end
      acc_ssum_q  <= '0;
      gyr_ssum_q  <= '0;
      acc_lsum_q  <= '0;
      gyr_lsum_q  <= '0;
      spos_q      <= '0;
      sfill_q     <= '0;
      lpos_q      <= '0;
      long_full_q <= 1'b0;
      push_q      <= 1'b0;
      warm_q      <= 1'b1;
      period_q    <= '0;
      acc_over_q  <= 1'b0;
      gyr_over_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ACC_MULT:   acc_m7_q <= M7_W'(cfg_data_i[ACC_MULT_W-1:0] * SHORT_LEN);
          CFG_GYRO_MULT:  gyr_m7_q <= M7_W'(cfg_data_i[GYRO_MULT_W-1:0] * SHORT_LEN);
          CFG_LTA_PERIOD: lta_q    <= cfg_data_i[PERIOD_W-1:0];
          default: ;
        endcase
      end

      if (cmd_i.short_upd) begin
        warm_q <= !long_full_q;
        push_q <= !long_full_q || per_hit;
        if (long_full_q) begin
          acc_ssum_q <= acc_ssum_q - SSUM_W'(acc_sring_q[spos_q]) + SSUM_W'(am);
          gyr_ssum_q <= gyr_ssum_q - SSUM_W'(gyr_sring_q[spos_q]) + SSUM_W'(gm);
          acc_sring_q[spos_q] <= am;
          gyr_sring_q[spos_q] <= gm;
          spos_q <= (spos_q == SPOS_W'(SHORT_LEN - 1)) ? '0 : spos_q + SPOS_W'(1);
          if (sfill_q != SFILL_W'(SHORT_LEN)) begin
            sfill_q <= sfill_q + SFILL_W'(1);
          end
          period_q <= per_hit ? '0 : period_q + PERIOD_W'(1);
        end
      end

      if (lr_we) begin
        acc_lsum_q <= acc_lsum_q - LSUM_W'(old_a) + LSUM_W'(am);
        gyr_lsum_q <= gyr_lsum_q - LSUM_W'(old_g) + LSUM_W'(gm);
        if (lpos_q == LPOS_W'(LONG_LEN - 1)) begin
          lpos_q      <= '0;
          long_full_q <= 1'b1;
        end else begin
          lpos_q <= lpos_q + LPOS_W'(1);
        end
      end

      if (cmd_i.load) begin
        acc_over_q <= 1'b0;
        gyr_over_q <= 1'b0;
      end
      if (cmd_i.acc_cmp) begin
        acc_over_q <= lhs_q > prod_q;
      end
      if (cmd_i.gyr_cmp) begin
        gyr_over_q <= lhs_q > prod_q;
      end

      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        out_data_q  <= out_word;
        // trigger empties the short rings
        if (acc_ok || gyr_ok) begin
          for (int i = 0; i < SHORT_LEN; i++) begin
            acc_sring_q[i] <= '0;
            gyr_sring_q[i] <= '0;
          end
          acc_ssum_q <= '0;
          gyr_ssum_q <= '0;
          spos_q     <= '0;
          sfill_q    <= '0;
        end
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || m_ready_i;
  assign sts_o.warm     = warm_q;
  assign m_valid_o      = out_valid_q;
  assign m_data_o       = out_data_q;

  `SLMT_ASSERT(a_fill_bound, sfill_q <= SFILL_W'(SHORT_LEN), "short fill beyond ring length")
  `SLMT_ASSERT_NEXT(a_armed_sticky, long_full_q, long_full_q, "long rings lost full state")
  `SLMT_ASSERT_IMPL(a_alarm_armed, out_valid_q && out_data_q[F_ALARM], out_data_q[F_ARMED], "alarm unarmed")

endmodule

`default_nettype wire

// ----- rtl/sta_lta_motion_trigger.sv -----
// top level of the short-term / long-term average motion trigger
// depends on slmt_pkg, slmt_ctrl and slmt_dp
//
// usage
// - s_axis carries one six-axis sample per word; the block takes a word only
//   when its sequencer is idle, so s_axis_tready drops while a sample is at work
// - m_axis carries one result word per sample, in order
// - cfg writes one register per handshake, index 0 acc_mult, 1 gyro_mult,
//   2 lta_period, index 3 ignored; cfg_ready_o is always high; write only
//   while no sample is in flight
// - steps: each sample passes through the square steps on the single shared
//   multiplier, 16 root steps, the ring update, the ratio test and the result
//   step; warm-up skips the ratio test
// - stall: the result sits in an output register, so a new sample is taken
//   while it waits; that sample is held at its last step until m_axis_tready
// - reset: rings empty, sums zero, registers at their defaults; the first 70
//   samples only fill the long rings; armed reads low until the 70th sample
`default_nettype none

module sta_lta_motion_trigger
  import slmt_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // sample stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // acc_x, acc_y, acc_z, gyr_x, gyr_y, gyr_z, 16 bit each from bit 0 up
  input  wire logic [IN_W-1:0]       s_axis_tdata,
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // alarm, acc_over, gyr_over, armed from bit 0 up, bits 7:4 zero
  output logic [OUT_W-1:0]           m_axis_tdata,
  // register writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  slmt_cmd_t cmd;
  slmt_sts_t sts;
  logic      s_accept;

  // registers take a write in any cycle
  assign cfg_ready_o = 1'b1;
  assign s_accept    = s_axis_tvalid && s_axis_tready;

  // sequencer: squares, root steps, ring update, ratio test, result
  slmt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (s_accept),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // datapath holds the rings, sums, registers and the output word
  slmt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .s_data_i    (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (m_axis_tdata)
  );

endmodule

`default_nettype wire
